/* design/pps_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// Shared constants, types and helpers for the preemptive priority scheduler.
// No dependencies; used by pps_cell and preemptive_priority_scheduler_top.
package pps_pkg;

	localparam int MAX_PROCS = 32;
	localparam int PRIO_BITS = 8;
	localparam int IDX_W     = $clog2(MAX_PROCS);
	localparam int CNT_W     = $clog2(MAX_PROCS + 1);
	localparam int TIME_W    = 24;
	localparam int ARR_W     = 16;
	localparam int BUR_W     = 16;
	localparam int IN_PRIO_W = 8;
	localparam int ID_W      = 6;
	localparam int IN_DATA_W = 40;
	localparam int OUT_DATA_W = 104;

	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [TIME_W-1:0]    time_t;
	typedef logic [ARR_W-1:0]     arr_t;
	typedef logic [BUR_W-1:0]     bur_t;
	typedef logic [PRIO_BITS-1:0] prio_t;
	typedef logic [ID_W-1:0]      id_t;

	// best candidate so far, handed from cell to cell
	typedef struct packed {
		logic  valid;
		idx_t  idx;
		prio_t prio;
		arr_t  arr;
		bur_t  burst;
		bur_t  rem;
	} best_t;

	// command broadcast to every cell
	typedef struct packed {
		logic  load;
		logic  dec;
		idx_t  idx;
		arr_t  arr;
		bur_t  burst;
		prio_t prio;
		time_t now;
	} cell_cmd_t;

	function automatic prio_t to_prio(input logic [IN_PRIO_W-1:0] p);
		return prio_t'(p);
	endfunction

	// slot index to process id (load order plus one), kept to ID_W bits
	function automatic id_t to_id(input idx_t idx);
		logic [IDX_W:0] t;
		t = {1'b0, idx} + 1'b1;
		return id_t'(t);
	endfunction

endpackage
`default_nettype wire

/* design/pps_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// One table slot: holds a process entry and merges it into the best
// candidate passed along the chain. Depends on pps_pkg.
module pps_cell (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire pps_pkg::idx_t    slot,
	input  wire pps_pkg::cell_cmd_t cmd,
	input  wire pps_pkg::best_t   best_in,
	output pps_pkg::best_t        best_out
);

	pps_pkg::arr_t  arr_q;
	pps_pkg::bur_t  burst_q;
	pps_pkg::bur_t  rem_q;
	pps_pkg::prio_t prio_q;
	logic           valid_q;
	logic           done_q;
	pps_pkg::best_t best_q;

	logic eligible;
	logic take_own;
	logic hit;

	assign hit      = (cmd.idx == slot);
	assign eligible = valid_q && !done_q && (pps_pkg::TIME_W'(arr_q) <= cmd.now);
	// strict compares: on a full tie the lower slot (earlier load) keeps it
	assign take_own = eligible && (!best_in.valid || (prio_q < best_in.prio) ||
		((prio_q == best_in.prio) && (arr_q < best_in.arr)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			done_q  <= 1'b0;
			best_q  <= '0;
		end else begin
			if (cmd.load && hit) begin
				valid_q <= 1'b1;
				done_q  <= 1'b0;
			end else if (cmd.dec && hit && rem_q == pps_pkg::BUR_W'(1)) begin
				done_q <= 1'b1;
			end
			if (take_own) begin
				best_q.valid <= 1'b1;
				best_q.idx   <= slot;
				best_q.prio  <= prio_q;
				best_q.arr   <= arr_q;
				best_q.burst <= burst_q;
				best_q.rem   <= rem_q;
			end else begin
				best_q <= best_in;
			end
		end
	end

	// entry payload, no reset
	always_ff @(posedge clk) begin
		if (cmd.load && hit) begin
			arr_q   <= cmd.arr;
			burst_q <= cmd.burst;
			rem_q   <= cmd.burst;
			prio_q  <= cmd.prio;
		end else if (cmd.dec && hit) begin
			rem_q <= rem_q - 1'b1;
		end
	end

	assign best_out = best_q;

endmodule
`default_nettype wire

/* design/preemptive_priority_scheduler_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Preemptive priority scheduler: a row of MAX_PROCS slot cells plus control.
// Load transfer: accepted with no result; loads can follow back to back.
// Tick transfer: the best-candidate token walks the cell chain one slot per cycle
// during the scan state, then the update and final states build and register
// the result; the input reopens with the result, so a new tick is not taken
// until the last one is through. A result still waiting to be taken holds the next tick
// in its last state and keeps the input closed.
// Reset (arst_n low, asynchronous) empties the table and zeroes the clock.
// Depends on pps_pkg and pps_cell.
module preemptive_priority_scheduler_top (
	input  wire                           clk,
	input  wire                           arst_n,
	// input stream
	input  wire                           s_tvalid,
	output logic                          s_tready,
	input  wire [pps_pkg::IN_DATA_W-1:0]  s_tdata,  // arrival[15:0], burst[31:16], prio[39:32]
	input  wire                           s_tuser,  // kind: 0 load, 1 tick
	// result stream
	output logic                          m_tvalid,
	input  wire                           m_tready,
	output logic [pps_pkg::OUT_DATA_W-1:0] m_tdata  // slot_start_time[23:0], running_id[29:24],
	                                                // finished[30], finish_time[54:31],
	                                                // turnaround[78:55], waiting[102:79],
	                                                // all_done[103]
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_FINAL
	} state_t;

	state_t             state_q;
	pps_pkg::idx_t      scan_cnt_q;
	pps_pkg::cnt_t      entry_cnt_q;
	pps_pkg::cnt_t      fin_cnt_q;
	pps_pkg::time_t     time_q;

	// tick result held between update and output
	pps_pkg::time_t     res_start_q;
	pps_pkg::id_t       res_id_q;
	logic               res_fin_q;
	pps_pkg::time_t     res_ftime_q;
	pps_pkg::time_t     res_turn_q;
	pps_pkg::bur_t      res_burst_q;

	logic [pps_pkg::OUT_DATA_W-1:0] m_tdata_q;
	logic               m_tvalid_q;

	// input field unpacking
	pps_pkg::arr_t      in_arr;
	pps_pkg::bur_t      in_burst;
	logic [pps_pkg::IN_PRIO_W-1:0] in_prio;
	logic               in_xfer;
	logic               load_ok;

	pps_pkg::cell_cmd_t cmd;
	pps_pkg::best_t     chain [pps_pkg::MAX_PROCS+1];
	pps_pkg::best_t     win;

	pps_pkg::time_t     time_next;
	pps_pkg::time_t     wait_val;
	logic               win_fin;
	logic               out_free;

	assign in_arr   = s_tdata[15:0];
	assign in_burst = s_tdata[31:16];
	assign in_prio  = s_tdata[39:32];

	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	// full table or zero burst: the load is dropped
	assign load_ok  = in_xfer && (s_tuser == pps_pkg::KIND_LOAD) &&
		(entry_cnt_q < pps_pkg::CNT_W'(pps_pkg::MAX_PROCS)) && (in_burst != '0);

	// broadcast: loads write the next free slot, the update decrements the winner
	always_comb begin
		cmd       = '0;
		cmd.now   = time_q;
		cmd.arr   = in_arr;
		cmd.burst = in_burst;
		cmd.prio  = pps_pkg::to_prio(in_prio);
		if (load_ok) begin
			cmd.load = 1'b1;
			cmd.idx  = entry_cnt_q[pps_pkg::IDX_W-1:0];
		end else if (state_q == ST_UPDATE) begin
			cmd.dec = win.valid;
			cmd.idx = win.idx;
		end
	end

	// cell chain: the token enters empty at slot 0 and leaves at the last slot
	assign chain[0] = '0;
	for (genvar g = 0; g < pps_pkg::MAX_PROCS; g++) begin : g_cell
		pps_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.slot     (pps_pkg::idx_t'(g)),
			.cmd      (cmd),
			.best_in  (chain[g]),
			.best_out (chain[g+1])
		);
	end
	assign win = chain[pps_pkg::MAX_PROCS];

	assign time_next = (time_q != pps_pkg::TIME_MAX) ? time_q + 1'b1 : time_q;
	assign win_fin   = win.valid && (win.rem == pps_pkg::BUR_W'(1));
	// waiting clamps at zero when saturated time makes it negative
	assign wait_val  = (res_turn_q >= pps_pkg::TIME_W'(res_burst_q)) ?
		res_turn_q - pps_pkg::TIME_W'(res_burst_q) : '0;
	assign out_free  = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scan_cnt_q  <= '0;
			entry_cnt_q <= '0;
			fin_cnt_q   <= '0;
			time_q      <= '0;
			res_start_q <= '0;
			res_id_q    <= '0;
			res_fin_q   <= 1'b0;
			res_ftime_q <= '0;
			res_turn_q  <= '0;
			res_burst_q <= '0;
			m_tdata_q   <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			// in the final state the output register is handled below
			if (m_tvalid_q && m_tready && state_q != ST_FINAL)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (load_ok)
						entry_cnt_q <= entry_cnt_q + 1'b1;
					if (in_xfer && s_tuser == pps_pkg::KIND_TICK) begin
						scan_cnt_q <= '0;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// wait for the token to cross every slot
					scan_cnt_q <= scan_cnt_q + 1'b1;
					if (scan_cnt_q == pps_pkg::idx_t'(pps_pkg::MAX_PROCS - 1))
						state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					time_q      <= time_next;
					res_start_q <= time_q;
					res_id_q    <= win.valid ? pps_pkg::to_id(win.idx) : '0;
					res_fin_q   <= win_fin;
					res_ftime_q <= win_fin ? time_next : '0;
					res_turn_q  <= win_fin ? time_next - pps_pkg::TIME_W'(win.arr) : '0;
					res_burst_q <= win.burst;
					if (win_fin)
						fin_cnt_q <= fin_cnt_q + 1'b1;
					state_q <= ST_FINAL;
				end
				ST_FINAL: begin
					if (out_free) begin
						m_tdata_q  <= {(fin_cnt_q == entry_cnt_q), wait_val, res_turn_q,
							res_ftime_q, res_fin_q, res_id_q, res_start_q};
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// table never overfills, and completions never outrun loads
	a_entry_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_cnt_q <= pps_pkg::CNT_W'(pps_pkg::MAX_PROCS))
		else $error("entry count beyond table size");

	a_fin_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fin_cnt_q <= entry_cnt_q)
		else $error("more completions than entries");

	// a completion always names a process
	a_fin_has_id: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[30]) |-> (m_tdata[29:24] != '0 || pps_pkg::MAX_PROCS == 64))
		else $error("finished without a running process");

	// a tick transfer blocks the input until its result is built
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == pps_pkg::KIND_TICK) |=> !s_tready)
		else $error("input taken during a tick");

endmodule
`default_nettype wire
